FILE: src/assert_macros.svh
// Assertion macros used by the checker module of the time-of-day clock.
// Plain SystemVerilog concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dtc_pkg.sv
// Package for the decimal time-of-day clock: field widths, day constants,
// reciprocal constants for the output divisions and the item function codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtc_pkg;

    localparam int MS_W  = 27;
    localparam int SEC_W = 17;
    localparam int DEC_W = 20;

    localparam logic [MS_W-1:0] DAY_MS      = 27'd86400000;
    localparam logic [MS_W-1:0] MS_PER_HOUR = 27'd3600000;
    localparam logic [MS_W-1:0] MS_PER_MIN  = 27'd60000;
    localparam logic [MS_W-1:0] MS_PER_SEC  = 27'd1000;

    // floor(ms / 1000) = (ms * SEC_RECIP) >> SEC_SHIFT for every ms below 2^27.
    localparam int               SEC_RECIP_W = 28;
    localparam logic [27:0]      SEC_RECIP   = 28'd137438954;
    localparam int               SEC_SHIFT   = 37;

    // floor(ms * 5 / 432) = (ms * DEC_RECIP) >> DEC_SHIFT for every ms below 2^27.
    localparam int               DEC_RECIP_W = 30;
    localparam logic [29:0]      DEC_RECIP   = 30'd795364315;
    localparam int               DEC_SHIFT   = 36;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_LOAD = 1'b1
    } t_func;

endpackage

`default_nettype wire

FILE: src/decimal_time_of_day_clock_unit.sv
// Channel  | dir | tdata (low bit up)                          | tuser
// s_axis   | in  | set_hour[4:0], set_minute[10:5],            | func[0]
//          |     | set_second[16:11], zero pad [23:17]         |
// m_axis   | out | ms_today[26:0], seconds_today[43:27],       | -
//          |     | decimal_time[63:44]                         |
//
// One item per cycle while results are taken. An accepted item is registered in
// the first stage, which updates the day count (set adder and wrap compare); the
// second stage runs two reciprocal multipliers into the output register.
// While a result waits, one more item enters the empty middle stage; after that
// tready stays low until the result is taken. Synchronous active-low reset
// clears the count to midnight and empties both stages.
// Top level of the decimal time-of-day clock. Depends on dtc_pkg and dtc_split.
`timescale 1ns / 1ps
`default_nettype none

module decimal_time_of_day_clock_unit
    import dtc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // set_hour, set_minute, set_second
    input  wire logic [0:0]  i_s_axis_tuser,   // func
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [63:0] o_m_axis_tdata    // ms_today, seconds_today, decimal_time
);

    logic [4:0]       w_hour;
    logic [5:0]       w_minute;
    logic [5:0]       w_second;
    logic [MS_W-1:0]  w_set_sum;
    logic [MS_W-1:0]  w_set_ms;
    logic [MS_W-1:0]  w_tick_ms;
    logic [MS_W-1:0]  n_ms;
    logic [SEC_W-1:0] w_seconds;
    logic [DEC_W-1:0] w_decimal;
    logic             w_out_en;
    logic             w_mid_en;
    logic             w_accept;

    logic [MS_W-1:0]  r_ms;
    logic             r_mid_vld;
    logic             r_out_vld;
    logic [MS_W-1:0]  r_out_ms;
    logic [SEC_W-1:0] r_out_sec;
    logic [DEC_W-1:0] r_out_dec;

    assign w_hour   = i_s_axis_tdata[4:0];
    assign w_minute = i_s_axis_tdata[10:5];
    assign w_second = i_s_axis_tdata[16:11];

    assign w_out_en = !r_out_vld || i_m_axis_tready;
    assign w_mid_en = !r_mid_vld || w_out_en;
    assign w_accept = i_s_axis_tvalid && w_mid_en;

    // Even out-of-range fields stay below twice a day, so one subtraction reduces them.
    assign w_set_sum = MS_W'(w_hour) * MS_PER_HOUR + MS_W'(w_minute) * MS_PER_MIN
                     + MS_W'(w_second) * MS_PER_SEC;
    assign w_set_ms  = (w_set_sum >= DAY_MS) ? w_set_sum - DAY_MS : w_set_sum;
    assign w_tick_ms = (r_ms == DAY_MS - MS_W'(1)) ? '0 : r_ms + MS_W'(1);

    always_comb begin
        case (t_func'(i_s_axis_tuser[0]))
            FUNC_LOAD: n_ms = w_set_ms;
            default:   n_ms = w_tick_ms;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms      <= '0;
            r_mid_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_ms <= n_ms;
            end
            if (w_mid_en) begin
                r_mid_vld <= w_accept;
            end
            if (w_out_en) begin
                r_out_vld <= r_mid_vld;
            end
        end
    end

    dtc_split u_split (
        .i_ms      (r_ms),
        .o_seconds (w_seconds),
        .o_decimal (w_decimal)
    );

    always_ff @(posedge i_clk) begin
        if (w_out_en && r_mid_vld) begin
            r_out_ms  <= r_ms;
            r_out_sec <= w_seconds;
            r_out_dec <= w_decimal;
        end
    end

    assign o_s_axis_tready = w_mid_en;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_dec, r_out_sec, r_out_ms};

endmodule

`default_nettype wire

FILE: src/dtc_split.sv
// Splits a millisecond-of-day count into whole seconds and decimal time
// (millionths of a day) with reciprocal multiplications. Depends on dtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtc_split
    import dtc_pkg::*;
(
    input  wire logic [MS_W-1:0]  i_ms,
    output logic      [SEC_W-1:0] o_seconds,
    output logic      [DEC_W-1:0] o_decimal
);

    localparam int SEC_PROD_W = MS_W + SEC_RECIP_W;
    localparam int DEC_PROD_W = MS_W + DEC_RECIP_W;

    logic [SEC_PROD_W-1:0] w_sec_prod;
    logic [DEC_PROD_W-1:0] w_dec_prod;

    assign w_sec_prod = SEC_PROD_W'(i_ms) * SEC_PROD_W'(SEC_RECIP);
    assign w_dec_prod = DEC_PROD_W'(i_ms) * DEC_PROD_W'(DEC_RECIP);

    // The rounding error of each reciprocal stays below one unit of the
    // quotient over the whole day, so the truncated product is exact.
    assign o_seconds = w_sec_prod[SEC_SHIFT +: SEC_W];
    assign o_decimal = w_dec_prod[DEC_SHIFT +: DEC_W];

endmodule

`default_nettype wire

FILE: src/dtc_checker.sv
// Port-level checker for the decimal time-of-day clock, bound to the top level.
// Depends on dtc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dtc_checker
    import dtc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [23:0] i_s_axis_tdata,
    input wire logic [0:0]  i_s_axis_tuser,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [63:0] o_m_axis_tdata
);

    logic            w_in_acc;
    logic            w_is_load;
    logic [MS_W-1:0] w_sum;
    logic [MS_W-1:0] w_exp_ms;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_load = (i_s_axis_tuser[0] == FUNC_LOAD);
    assign w_sum     = MS_W'(i_s_axis_tdata[4:0]) * MS_PER_HOUR
                     + MS_W'(i_s_axis_tdata[10:5]) * MS_PER_MIN
                     + MS_W'(i_s_axis_tdata[16:11]) * MS_PER_SEC;
    assign w_exp_ms  = (w_sum >= DAY_MS) ? w_sum - DAY_MS : w_sum;

    // A stalled result keeps its place and its value.
    `DTC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

    // Nothing is offered straight after reset.
    `DTC_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_m_axis_tvalid, "result offered after reset")

    // An accepted item reaches the output once the output side is free.
    `DTC_ASSERT_NEXT(a_latency, i_clk, i_rst_n, w_in_acc ##1 i_m_axis_tready, o_m_axis_tvalid, "accepted item not delivered")

    // A load item shows the loaded time of day, reduced to one day.
    `DTC_ASSERT_NEXT(a_load_value, i_clk, i_rst_n, w_in_acc && w_is_load ##1 i_m_axis_tready, o_m_axis_tdata[MS_W-1:0] == $past(w_exp_ms, 2), "loaded time wrong")

endmodule

bind decimal_time_of_day_clock_unit dtc_checker u_dtc_checker (.*);

`default_nettype wire
